@@ design/blca_pkg.sv @@
// ----------------------------------------------------------------------------
// blca_pkg: shared types and constants for the binary lifting LCA block
// Operation codes, command format between front and back, back-end states.
// ----------------------------------------------------------------------------
package blca_pkg;

    localparam int NODE_W     = 10;   // port width of a node number
    localparam int DEPTH_W    = 10;   // port width of a node depth
    localparam int OP_W       = 2;
    localparam int RANGE_W    = 17;   // wide enough to compare against NODES
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 11;
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // MISS: query that names a node out of range, answered not found
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_BUILD,
        CMD_QUERY,
        CMD_MISS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic [NODE_W-1:0]  par;
        logic               par_pres;
        logic [DEPTH_W-1:0] dep;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD,
        S_QDA,
        S_QDB,
        S_LIFT,
        S_LIFTW,
        S_CHECK,
        S_DESC,
        S_FINAL,
        S_OUT
    } t_state;

endpackage

@@ design/blca_ram.sv @@
// ----------------------------------------------------------------------------
// blca_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module blca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/blca_front.sv @@
// ----------------------------------------------------------------------------
// blca_front: input stage
// Accepts transactions, range-checks nodes, drops unused ops and out-of-range
// loads and registers one classified command for the command queue.
// ----------------------------------------------------------------------------
module blca_front
    import blca_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    input  logic [NODE_W-1:0]  i_parent_node,
    input  logic               i_is_root,
    input  logic [DEPTH_W-1:0] i_node_depth,
    output logic               o_push,
    output t_cmd               o_cmd,
    input  logic               i_full
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic keep;
    logic a_ok, b_ok, par_ok;
    logic accept;

    assign a_ok   = RANGE_W'(i_node_a) < RANGE_W'(NODES);
    assign b_ok   = RANGE_W'(i_node_b) < RANGE_W'(NODES);
    assign par_ok = RANGE_W'(i_parent_node) < RANGE_W'(NODES);

    always_comb begin
        keep           = 1'b0;
        n_cmd.kind     = CMD_LOAD;
        n_cmd.a        = i_node_a;
        n_cmd.b        = i_node_b;
        n_cmd.par      = i_parent_node;
        n_cmd.par_pres = !i_is_root && par_ok;
        n_cmd.dep      = i_node_depth;
        case (t_op'(i_operation))
            OP_LOAD: begin
                keep       = a_ok;
                n_cmd.kind = CMD_LOAD;
            end
            OP_BUILD: begin
                keep       = 1'b1;
                n_cmd.kind = CMD_BUILD;
            end
            OP_QUERY: begin
                keep       = 1'b1;
                n_cmd.kind = (a_ok && b_ok) ? CMD_QUERY : CMD_MISS;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept && keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ design/blca_cmdq.sv @@
// ----------------------------------------------------------------------------
// blca_cmdq: command queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module blca_cmdq
    import blca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == CW'(CMDQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ design/blca_back.sv @@
// ----------------------------------------------------------------------------
// blca_back: execution engine
// Runs load, table build and query commands against the ancestor table
// (two mirrored copies for two reads a cycle) and the depth store.
// ----------------------------------------------------------------------------
module blca_back
    import blca_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [NODE_W-1:0]  o_ancestor,
    output logic               o_found
);

    localparam int NW     = $clog2(NODES);
    localparam int LW     = $clog2(LEVELS);
    localparam int TAW    = LW + NW;
    localparam int TDEPTH = LEVELS * (2 ** NW);
    localparam int EW     = NW + 1;   // present bit on top of the node number

    t_state r_state, n_state;

    logic [NW-1:0]      r_a, n_a, r_b, n_b;
    logic [DEPTH_W-1:0] r_da, n_da;
    logic [DEPTH_W-1:0] r_diff, n_diff;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [NW-1:0]      r_bv, n_bv;
    logic               r_bissue, n_bissue;
    logic               r_p1_valid, n_p1_valid;
    logic [NW-1:0]      r_p1_v, n_p1_v;
    logic               r_p2_valid, n_p2_valid;
    logic [NW-1:0]      r_p2_v, n_p2_v;
    logic               r_p2_pres, n_p2_pres;
    logic [NW-1:0]      r_res_node, n_res_node;
    logic               r_res_found, n_res_found;
    logic               r_out_valid, n_out_valid;
    logic [NODE_W-1:0]  r_out_anc, n_out_anc;
    logic               r_out_found, n_out_found;

    // table and depth store ports
    logic               tbl_we;
    logic [TAW-1:0]     tbl_waddr;
    logic [EW-1:0]      tbl_wdata;
    logic               re_a, re_b;
    logic [TAW-1:0]     raddr_a, raddr_b;
    logic [EW-1:0]      rd_a, rd_b;
    logic               dep_we, dep_re;
    logic [NW-1:0]      dep_waddr, dep_raddr;
    logic [DEPTH_W-1:0] dep_wdata, dep_rdata;

    logic [LW-1:0]      lvl_m1;
    logic [NW-1:0]      na, nb;
    logic               move;
    logic [DEPTH_W-1:0] diff;
    logic               db_gt;

    assign lvl_m1 = r_lvl - LW'(1);
    assign db_gt  = dep_rdata > r_da;
    assign diff   = db_gt ? (dep_rdata - r_da) : (r_da - dep_rdata);
    assign move   = rd_a[NW] && rd_b[NW] && (rd_a[NW-1:0] != rd_b[NW-1:0]);
    assign na     = move ? rd_a[NW-1:0] : r_a;
    assign nb     = move ? rd_b[NW-1:0] : r_b;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_da        = r_da;
        n_diff      = r_diff;
        n_lvl       = r_lvl;
        n_bv        = r_bv;
        n_bissue    = r_bissue;
        n_p1_valid  = 1'b0;
        n_p1_v      = r_p1_v;
        n_p2_valid  = 1'b0;
        n_p2_v      = r_p2_v;
        n_p2_pres   = r_p2_pres;
        n_res_node  = r_res_node;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid && !i_ready;
        n_out_anc   = r_out_anc;
        n_out_found = r_out_found;
        o_pop       = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = {LW'(0), NW'(i_cmd.a)};
        tbl_wdata   = {i_cmd.par_pres, NW'(i_cmd.par)};
        re_a        = 1'b0;
        re_b        = 1'b0;
        raddr_a     = {r_lvl, r_a};
        raddr_b     = {r_lvl, r_b};
        dep_we      = 1'b0;
        dep_waddr   = NW'(i_cmd.a);
        dep_wdata   = i_cmd.dep;
        dep_re      = 1'b0;
        dep_raddr   = NW'(i_cmd.a);

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_LOAD: begin
                            // level 0 entry and depth written in the same cycle
                            tbl_we = 1'b1;
                            dep_we = 1'b1;
                        end
                        CMD_BUILD: begin
                            n_lvl    = LW'(1);
                            n_bv     = '0;
                            n_bissue = 1'b1;
                            n_state  = S_BUILD;
                        end
                        CMD_QUERY: begin
                            dep_re  = 1'b1;
                            n_a     = NW'(i_cmd.a);
                            n_b     = NW'(i_cmd.b);
                            n_state = S_QDA;
                        end
                        CMD_MISS: begin
                            n_res_found = 1'b0;
                            n_res_node  = '0;
                            n_state     = S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_BUILD: begin
                // three-stage sweep: read (v,k-1), read (mid,k-1), write (v,k)
                if (r_bissue) begin
                    re_a       = 1'b1;
                    raddr_a    = {lvl_m1, r_bv};
                    n_p1_valid = 1'b1;
                    n_p1_v     = r_bv;
                    n_bv       = r_bv + NW'(1);
                    if (r_bv == NW'(NODES - 1)) begin
                        n_bissue = 1'b0;
                    end
                end
                if (r_p1_valid) begin
                    re_b       = 1'b1;
                    raddr_b    = {lvl_m1, rd_a[NW-1:0]};
                    n_p2_valid = 1'b1;
                    n_p2_v     = r_p1_v;
                    n_p2_pres  = rd_a[NW];
                end
                if (r_p2_valid) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = {r_lvl, r_p2_v};
                    tbl_wdata = r_p2_pres ? rd_b : '0;
                end
                // level done once the sweep has drained
                if (!r_bissue && !r_p1_valid && !r_p2_valid) begin
                    if (r_lvl == LW'(LEVELS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_lvl    = r_lvl + LW'(1);
                        n_bv     = '0;
                        n_bissue = 1'b1;
                    end
                end
            end

            S_QDA: begin
                dep_re    = 1'b1;
                dep_raddr = r_b;
                n_da      = dep_rdata;
                n_state   = S_QDB;
            end

            S_QDB: begin
                // deeper node goes to a
                if (db_gt) begin
                    n_a = r_b;
                    n_b = r_a;
                end
                if ((32'(diff) >> LEVELS) != 32'd0) begin
                    n_res_found = 1'b0;
                    n_res_node  = '0;
                    n_state     = S_OUT;
                end else begin
                    n_diff  = diff;
                    n_lvl   = '0;
                    n_state = S_LIFT;
                end
            end

            S_LIFT: begin
                if (r_diff == '0) begin
                    n_state = S_CHECK;
                end else if (r_diff[0]) begin
                    re_a    = 1'b1;
                    raddr_a = {r_lvl, r_a};
                    n_state = S_LIFTW;
                end else begin
                    n_diff = r_diff >> 1;
                    n_lvl  = r_lvl + LW'(1);
                end
            end

            S_LIFTW: begin
                if (!rd_a[NW]) begin
                    n_res_found = 1'b0;
                    n_res_node  = '0;
                    n_state     = S_OUT;
                end else begin
                    n_a     = rd_a[NW-1:0];
                    n_diff  = r_diff >> 1;
                    n_lvl   = r_lvl + LW'(1);
                    n_state = S_LIFT;
                end
            end

            S_CHECK: begin
                if (r_a == r_b) begin
                    n_res_found = 1'b1;
                    n_res_node  = r_a;
                    n_state     = S_OUT;
                end else begin
                    n_lvl   = LW'(LEVELS - 1);
                    re_a    = 1'b1;
                    re_b    = 1'b1;
                    raddr_a = {LW'(LEVELS - 1), r_a};
                    raddr_b = {LW'(LEVELS - 1), r_b};
                    n_state = S_DESC;
                end
            end

            S_DESC: begin
                // one level a cycle, next read issued from this decision
                n_a  = na;
                n_b  = nb;
                re_a = 1'b1;
                re_b = 1'b1;
                if (r_lvl == '0) begin
                    raddr_a = {LW'(0), na};
                    raddr_b = {LW'(0), nb};
                    n_state = S_FINAL;
                end else begin
                    raddr_a = {lvl_m1, na};
                    raddr_b = {lvl_m1, nb};
                    n_lvl   = lvl_m1;
                end
            end

            S_FINAL: begin
                n_res_found = rd_a[NW] && (rd_a == rd_b);
                n_res_node  = (rd_a[NW] && (rd_a == rd_b)) ? rd_a[NW-1:0] : '0;
                n_state     = S_OUT;
            end

            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = NODE_W'(r_res_node);
                    n_out_found = r_res_found;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bissue    <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bissue    <= n_bissue;
            r_p1_valid  <= n_p1_valid;
            r_p2_valid  <= n_p2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_da        <= n_da;
        r_diff      <= n_diff;
        r_lvl       <= n_lvl;
        r_bv        <= n_bv;
        r_p1_v      <= n_p1_v;
        r_p2_v      <= n_p2_v;
        r_p2_pres   <= n_p2_pres;
        r_res_node  <= n_res_node;
        r_res_found <= n_res_found;
        r_out_anc   <= n_out_anc;
        r_out_found <= n_out_found;
    end

    assign o_valid    = r_out_valid;
    assign o_ancestor = r_out_anc;
    assign o_found    = r_out_found;

    // ancestor table, copy A
    blca_ram #(
        .WIDTH (EW),
        .DEPTH (TDEPTH)
    ) u_tbl_a (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    // ancestor table, copy B (same writes, second read port)
    blca_ram #(
        .WIDTH (EW),
        .DEPTH (TDEPTH)
    ) u_tbl_b (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    blca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODES)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_re    (dep_re),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

endmodule

@@ design/binary_lifting_lca.sv @@
// ----------------------------------------------------------------------------
// binary_lifting_lca: lowest common ancestor by binary lifting
// Usage:
//  - Input channel i_valid/o_ready carries one transaction per command:
//    load (node, parent or root mark, depth), build, or query (node_a, node_b).
//  - Output channel o_valid/i_ready carries one transaction per query only:
//    o_ancestor and o_found (ancestor reads 0 when not found).
//  - Load: level 0 entry and depth are written together in the back end. Build:
//    a three-stage sweep over every node per level.
//  - Query: the deeper node is lifted first, then both nodes descend; two
//    table reads per cycle during the descent, while the lift uses one
//    table read port.
//  - Commands are processed one at a time. A two-entry command queue plus an
//    input register let up to three commands wait while the back end works.
//  - A finished result sits in the output register; a stalled receiver holds
//    it there and the next query waits after its answer is computed.
//  - Reset clears control and handshake state only. Tables are undefined until
//    loaded and built; there is no clearing pass.
// ----------------------------------------------------------------------------
module binary_lifting_lca
    import blca_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    input  logic [NODE_W-1:0]  i_parent_node,
    input  logic               i_is_root,
    input  logic [DEPTH_W-1:0] i_node_depth,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [NODE_W-1:0]  o_ancestor,
    output logic               o_found
);

    // front -> queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue -> back
    logic pop;
    logic q_empty;
    t_cmd head_cmd;

    // Front: classifies transactions; unused op codes and out-of-range loads
    // are dropped here, out-of-range queries become a not-found command.
    blca_front #(
        .NODES (NODES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_parent_node (i_parent_node),
        .i_is_root     (i_is_root),
        .i_node_depth  (i_node_depth),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_full        (q_full)
    );

    blca_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Back: table memories, build sweep, lift and descent sequencer,
    // output register.
    blca_back #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ancestor (o_ancestor),
        .o_found    (o_found)
    );

endmodule
